>>> rtl/core/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants of the triangle span rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

  // Fixed geometry
  localparam int unsigned SLOPE_FRAC        = 16;
  localparam int unsigned COORD_W           = 16;
  localparam int unsigned SLOPE_W           = 32;
  localparam int unsigned COLOUR_W          = 24;
  localparam int unsigned ROW_W             = 12;
  localparam int unsigned COL_W             = 13;
  localparam int unsigned MAX_COORD         = 4096;

  // Parameter defaults
  localparam int unsigned TILE_ROWS_DEF     = 64;
  localparam int unsigned SUBPIXEL_BITS_DEF = 4;

  // Configuration port
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 13;
  localparam logic [CFG_AW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_TILE_TOP      = 2'd2;

  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [11:0] TILE_RST   = 12'd0;

  // Edge select for the shared divider
  localparam logic [1:0] EDGE_LONG  = 2'd0;
  localparam logic [1:0] EDGE_UPPER = 2'd1;
  localparam logic [1:0] EDGE_LOWER = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIDE_MUL,
    ST_SIDE_CMP,
    ST_ROW_MUL,
    ST_ROW_EVAL,
    ST_FLUSH
  } tsr_state_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_store;
    logic       side_mul;
    logic       side_cmp;
    logic       row_mul;
    logic       row_adv;
    logic       take_new;
    logic       emit_pend;
    logic       emit_last;
  } tsr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rows_empty;
    logic last_row;
    logic span_ok;
    logic pend_valid;
    logic out_free;
  } tsr_status_t;

endpackage

`default_nettype wire

>>> rtl/core/tsr_divider.sv
// ----------------------------------------------------------------------------
// tsr_divider
// Radix-2 restoring divider for edge slopes: dx * 2^16 / dy, truncated
// toward zero and saturated to signed 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_divider (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [tsr_pkg::COORD_W:0] dx,
  input  wire logic        [tsr_pkg::COORD_W:0] dy,
  output logic                                  done,
  output logic signed [tsr_pkg::SLOPE_W-1:0]    slope
);

  localparam int unsigned QW = tsr_pkg::SLOPE_W;
  localparam int unsigned RW = tsr_pkg::COORD_W + 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [RW-1:0] den_r, den_nxt;
  logic          neg_r, neg_nxt;

  logic [RW:0]   trial;
  logic [RW-1:0] absdx;

  assign absdx = dx[RW-1] ? RW'(-dx) : RW'(dx);
  assign trial = {rem_r, quo_r[QW-1]};

  // Iterate one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = {absdx[tsr_pkg::COORD_W-1:0], {tsr_pkg::SLOPE_FRAC{1'b0}}};
      den_nxt  = dy;
      neg_nxt  = dx[RW-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = RW'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[RW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // Apply sign, saturate, and force zero for a flat edge
  always_comb begin
    if (den_r == '0) begin
      slope = '0;
    end else if (neg_r) begin
      if (quo_r > {1'b1, {(QW-1){1'b0}}}) slope = {1'b1, {(QW-1){1'b0}}};
      else                                 slope = -$signed(quo_r);
    end else begin
      if (quo_r[QW-1]) slope = {1'b0, {(QW-1){1'b1}}};
      else             slope = $signed(quo_r);
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

>>> rtl/core/tsr_ctrl.sv
// ----------------------------------------------------------------------------
// tsr_ctrl
// Sequencer: triangle load, three slope divisions, side test, then a
// row walk (multiply, evaluate) with a one-span holding stage for the last mark.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tsr_pkg::tsr_status_t sts,
  output tsr_pkg::tsr_cmd_t        cmd
);

  tsr_pkg::tsr_state_t state_r, state_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                stall;

  // Hold a new span while the holding stage cannot drain
  assign stall = sts.span_ok && sts.pend_valid && !sts.out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      tsr_pkg::ST_IDLE: begin
        idx_nxt = tsr_pkg::EDGE_LONG;
        if (in_valid) state_nxt = tsr_pkg::ST_DIV_GO;
      end
      tsr_pkg::ST_DIV_GO: state_nxt = tsr_pkg::ST_DIV_WAIT;
      tsr_pkg::ST_DIV_WAIT: begin
        if (sts.div_done) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == tsr_pkg::EDGE_LOWER) state_nxt = tsr_pkg::ST_SIDE_MUL;
          else                              state_nxt = tsr_pkg::ST_DIV_GO;
        end
      end
      tsr_pkg::ST_SIDE_MUL: state_nxt = tsr_pkg::ST_SIDE_CMP;
      tsr_pkg::ST_SIDE_CMP: begin
        if (sts.rows_empty) state_nxt = tsr_pkg::ST_FLUSH;
        else                state_nxt = tsr_pkg::ST_ROW_MUL;
      end
      tsr_pkg::ST_ROW_MUL: state_nxt = tsr_pkg::ST_ROW_EVAL;
      tsr_pkg::ST_ROW_EVAL: begin
        if (!stall) begin
          if (sts.last_row) state_nxt = tsr_pkg::ST_FLUSH;
          else              state_nxt = tsr_pkg::ST_ROW_MUL;
        end
      end
      tsr_pkg::ST_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) state_nxt = tsr_pkg::ST_IDLE;
      end
      default: state_nxt = tsr_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    cmd.div_sel = idx_r;
    in_ready    = 1'b0;
    unique case (state_r)
      tsr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tsr_pkg::ST_DIV_GO:   cmd.div_start = 1'b1;
      tsr_pkg::ST_DIV_WAIT: cmd.div_store = sts.div_done;
      tsr_pkg::ST_SIDE_MUL: cmd.side_mul  = 1'b1;
      tsr_pkg::ST_SIDE_CMP: cmd.side_cmp  = 1'b1;
      tsr_pkg::ST_ROW_MUL:  cmd.row_mul   = 1'b1;
      tsr_pkg::ST_ROW_EVAL: begin
        if (!stall) begin
          cmd.row_adv   = 1'b1;
          cmd.take_new  = sts.span_ok;
          cmd.emit_pend = sts.span_ok && sts.pend_valid;
        end
      end
      tsr_pkg::ST_FLUSH: cmd.emit_last = sts.pend_valid && sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsr_pkg::ST_IDLE;
      idx_r   <= tsr_pkg::EDGE_LONG;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tsr_datapath.sv
// ----------------------------------------------------------------------------
// tsr_datapath
// Vertex sort, slope store, edge evaluation per row, column rounding with
// the top-left rule, clipping, span holding stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_datapath #(
  parameter int unsigned TILE_ROWS     = tsr_pkg::TILE_ROWS_DEF,
  parameter int unsigned SUBPIXEL_BITS = tsr_pkg::SUBPIXEL_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [(6*tsr_pkg::COORD_W)+tsr_pkg::COLOUR_W-1:0] in_data,
  input  wire logic                               cfg_we,
  input  wire logic [tsr_pkg::CFG_AW-1:0]         cfg_addr,
  input  wire logic [tsr_pkg::CFG_DW-1:0]         cfg_wdata,
  input  wire tsr_pkg::tsr_cmd_t                  cmd,
  output tsr_pkg::tsr_status_t                    sts,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic [tsr_pkg::ROW_W-1:0]               out_row,
  output logic [tsr_pkg::COL_W-1:0]               out_start,
  output logic [tsr_pkg::COL_W-1:0]               out_end,
  output logic [tsr_pkg::COLOUR_W-1:0]            out_colour,
  output logic                                    out_last
);

  localparam int unsigned CW16  = tsr_pkg::COORD_W;
  localparam int unsigned SW    = tsr_pkg::SLOPE_W;
  localparam int unsigned XSH   = tsr_pkg::SLOPE_FRAC + 1;
  localparam int unsigned DW    = SUBPIXEL_BITS + 18;
  localparam int unsigned PW    = SW + DW + 1;
  localparam int unsigned RSH   = SUBPIXEL_BITS + XSH;
  localparam int unsigned KW    = PW - RSH;
  localparam logic [PW-1:0] HALF_M1 = PW'((64'd1 << (RSH - 1)) - 64'd1);

  typedef logic signed [CW16-1:0] crd_t;

  // Configuration registers
  logic [12:0] width_r, height_r;
  logic [11:0] tile_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= tsr_pkg::WIDTH_RST;
      height_r <= tsr_pkg::HEIGHT_RST;
      tile_r   <= tsr_pkg::TILE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tsr_pkg::CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        tsr_pkg::CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        tsr_pkg::CFG_TILE_TOP:      tile_r   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Sort vertices by y, swapping only when strictly greater; ties need not keep input order
  crd_t ix [3];
  crd_t iy [3];
  crd_t s1x [3];
  crd_t s1y [3];
  crd_t s2x [3];
  crd_t s2y [3];
  crd_t sx [3];
  crd_t sy [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ix[i] = in_data[(2*i)*CW16 +: CW16];
      iy[i] = in_data[(2*i+1)*CW16 +: CW16];
    end
    s1x = ix; s1y = iy;
    if (iy[0] > iy[1]) begin
      s1x[0] = ix[1]; s1y[0] = iy[1]; s1x[1] = ix[0]; s1y[1] = iy[0];
    end
    s2x = s1x; s2y = s1y;
    if (s1y[0] > s1y[2]) begin
      s2x[0] = s1x[2]; s2y[0] = s1y[2]; s2x[2] = s1x[0]; s2y[2] = s1y[0];
    end
    sx = s2x; sy = s2y;
    if (s2y[1] > s2y[2]) begin
      sx[1] = s2x[2]; sy[1] = s2y[2]; sx[2] = s2x[1]; sy[2] = s2y[1];
    end
  end

  crd_t x_r [3];
  crd_t y_r [3];
  logic [tsr_pkg::COLOUR_W-1:0] colour_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= sx;
      y_r      <= sy;
      colour_r <= in_data[6*CW16 +: tsr_pkg::COLOUR_W];
    end
  end

  // Slope division, shared over the long, upper and lower edges
  logic signed [CW16:0] div_dx;
  logic        [CW16:0] div_dy;
  logic                 div_done;
  logic signed [SW-1:0] div_q;
  logic signed [SW-1:0] slope_r [3];

  always_comb begin
    unique case (cmd.div_sel)
      tsr_pkg::EDGE_UPPER: begin
        div_dx = (CW16+1)'(x_r[1]) - (CW16+1)'(x_r[0]);
        div_dy = (CW16+1)'(y_r[1]) - (CW16+1)'(y_r[0]);
      end
      tsr_pkg::EDGE_LOWER: begin
        div_dx = (CW16+1)'(x_r[2]) - (CW16+1)'(x_r[1]);
        div_dy = (CW16+1)'(y_r[2]) - (CW16+1)'(y_r[1]);
      end
      default: begin
        div_dx = (CW16+1)'(x_r[2]) - (CW16+1)'(x_r[0]);
        div_dy = (CW16+1)'(y_r[2]) - (CW16+1)'(y_r[0]);
      end
    endcase
  end

  tsr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dx    (div_dx),
    .dy    (div_dy),
    .done  (div_done),
    .slope (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_store) slope_r[cmd.div_sel] <= div_q;
  end

  // Row and limit tracking
  logic [12:0] row_r, rend_r;
  logic [12:0] width_eff, hlim, tile_end, rend_calc;

  assign width_eff = (width_r > 13'(tsr_pkg::MAX_COORD)) ? 13'(tsr_pkg::MAX_COORD) : width_r;
  assign hlim      = (height_r > 13'(tsr_pkg::MAX_COORD)) ? 13'(tsr_pkg::MAX_COORD) : height_r;
  assign tile_end  = {1'b0, tile_r} + 13'(TILE_ROWS);
  assign rend_calc = (tile_end > hlim) ? hlim : tile_end;

  always_ff @(posedge clk) begin
    if (cmd.side_mul) begin
      row_r  <= {1'b0, tile_r};
      rend_r <= rend_calc;
    end else if (cmd.row_adv) begin
      row_r <= row_r + 13'd1;
    end
  end

  // Half-resolution coordinates: y in 2^-(S+1) pixel units
  logic signed [DW-1:0] yc, y0d, y1d, y2d;
  logic signed [PW-1:0] bx0, bx1;

  assign yc  = $signed(DW'({row_r, 1'b1}) << SUBPIXEL_BITS);
  assign y0d = DW'(y_r[0]) <<< 1;
  assign y1d = DW'(y_r[1]) <<< 1;
  assign y2d = DW'(y_r[2]) <<< 1;
  assign bx0 = PW'(x_r[0]) <<< XSH;
  assign bx1 = PW'(x_r[1]) <<< XSH;

  // Multiply stage: long edge and short edge products
  logic signed [PW-1:0]    prod_l_r, prod_s_r;
  logic                    upper_r, cover_r, short_left_r;
  logic signed [DW-1:0]    mul_l_b, mul_s_b;
  logic signed [SW-1:0]    mul_l_a, mul_s_a;
  logic signed [SW+DW-1:0] mul_l_p, mul_s_p;
  logic                    upper;

  assign upper   = yc < y1d;
  assign mul_l_a = slope_r[0];
  assign mul_l_b = cmd.side_mul ? (y1d - y0d) : (yc - y0d);
  assign mul_s_a = upper ? slope_r[1] : slope_r[2];
  assign mul_s_b = upper ? (yc - y0d) : (yc - y1d);
  assign mul_l_p = mul_l_a * mul_l_b;
  assign mul_s_p = mul_s_a * mul_s_b;

  always_ff @(posedge clk) begin
    if (cmd.side_mul || cmd.row_mul) begin
      prod_l_r <= PW'(mul_l_p);
    end
    if (cmd.row_mul) begin
      prod_s_r <= PW'(mul_s_p);
      upper_r  <= upper;
      cover_r  <= (yc >= y0d) && (yc < y2d);
    end
    if (cmd.side_cmp) begin
      short_left_r <= bx1 < (bx0 + prod_l_r);
    end
  end

  // Evaluate stage: edge x, round to columns, clip
  logic signed [PW-1:0] xl, xsh, xleft, xright, rl, rr;
  logic signed [KW-1:0] cl, cr, c0, c1;

  assign xl     = bx0 + prod_l_r;
  assign xsh    = (upper_r ? bx0 : bx1) + prod_s_r;
  assign xleft  = short_left_r ? xsh : xl;
  assign xright = short_left_r ? xl : xsh;
  assign rl     = xleft + $signed(HALF_M1);
  assign rr     = xright + $signed(HALF_M1);
  assign cl     = KW'(rl >>> RSH);
  assign cr     = KW'(rr >>> RSH);
  assign c0     = (cl < 0) ? '0 : cl;
  assign c1     = (cr > $signed(KW'(width_eff))) ? $signed(KW'(width_eff)) : cr;

  // Holding stage and output register
  logic                        pend_valid_r, pend_valid_nxt;
  logic [tsr_pkg::ROW_W-1:0]   pend_row_r;
  logic [tsr_pkg::COL_W-1:0]   pend_start_r, pend_end_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [tsr_pkg::ROW_W-1:0]   out_row_r;
  logic [tsr_pkg::COL_W-1:0]   out_start_r, out_end_r;
  logic [tsr_pkg::COLOUR_W-1:0] out_colour_r;
  logic                        out_last_r;
  logic                        emit;

  assign emit = cmd.emit_pend || cmd.emit_last;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (cmd.take_new)       pend_valid_nxt = 1'b1;
    else if (cmd.emit_last) pend_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    if (cmd.take_new) begin
      pend_row_r   <= row_r[tsr_pkg::ROW_W-1:0];
      pend_start_r <= c0[tsr_pkg::COL_W-1:0];
      pend_end_r   <= c1[tsr_pkg::COL_W-1:0];
    end
    if (emit) begin
      out_row_r    <= pend_row_r;
      out_start_r  <= pend_start_r;
      out_end_r    <= pend_end_r;
      out_colour_r <= colour_r;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_start  = out_start_r;
  assign out_end    = out_end_r;
  assign out_colour = out_colour_r;
  assign out_last   = out_last_r;

  // Status to the sequencer
  always_comb begin
    sts            = '0;
    sts.div_done   = div_done;
    sts.rows_empty = row_r >= rend_r;
    sts.last_row   = (row_r + 13'd1) >= rend_r;
    sts.span_ok    = cover_r && (c0 < c1);
    sts.pend_valid = pend_valid_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

>>> rtl/core/triangle_span_rasteriser.sv
// ----------------------------------------------------------------------------
// triangle_span_rasteriser
// Scanline triangle fill with the top-left rule; one span per covered row
// of the current tile, clipped to the screen.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | content
//  in_      | in  | in_tvalid/in_tready   | one triangle (tdata)
//  out_     | out | out_tvalid/out_tready | one span (tdata), tlast on final span
//  cfg_     | in  | cfg_we                | width, height, tile top
//
//  Steps: take the triangle, three slope setups on the shared divider (start,
//  one quotient bit a cycle, then store), the side test, then a multiply and
//  an evaluate state per tile row (up to TILE_ROWS), and a flush of the held span.
//  Reset: synchronous rst_n; registers return to 640 x 480, tile 0.
//  Stalls: the row walk and the flush wait only when a held span cannot move
//  to a full output register; a new triangle is taken while the output
//  still holds.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_span_rasteriser #(
  parameter int unsigned TILE_ROWS     = tsr_pkg::TILE_ROWS_DEF,
  parameter int unsigned SUBPIXEL_BITS = tsr_pkg::SUBPIXEL_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, fill_colour
  input  wire logic [119:0]                in_tdata,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // span_row, span_start, span_end, span_colour, two zero pad bits
  output logic [63:0]                      out_tdata,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic                        cfg_we,
  input  wire logic [tsr_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [tsr_pkg::CFG_DW-1:0]  cfg_wdata
);

  tsr_pkg::tsr_cmd_t    cmd;
  tsr_pkg::tsr_status_t sts;

  logic [tsr_pkg::ROW_W-1:0]    row;
  logic [tsr_pkg::COL_W-1:0]    cstart, cend;
  logic [tsr_pkg::COLOUR_W-1:0] colour;

  tsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsr_datapath #(
    .TILE_ROWS     (TILE_ROWS),
    .SUBPIXEL_BITS (SUBPIXEL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_row    (row),
    .out_start  (cstart),
    .out_end    (cend),
    .out_colour (colour),
    .out_last   (out_tlast)
  );

  // Pack the span fields, lowest first
  assign out_tdata = {2'b00, colour, cend, cstart, row};

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle span rasteriser: random and directed
// triangles are streamed in, the spans each one should produce are worked
// out alongside and compared field by field with what comes out.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int TILE_H  = 64;
  localparam int SUB     = 4;
  localparam int LIMIT   = 2000000;

  typedef struct packed {
    logic [23:0] colour;
    logic [15:0] cy, cx, by, bx, ay, ax;
  } tri_t;

  typedef struct {
    logic [11:0] row;
    logic [12:0] start_col;
    logic [12:0] end_col;
    logic [23:0] colour;
    logic        last;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [119:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] out_tdata;
  logic out_tlast, out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [tsr_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [tsr_pkg::CFG_DW-1:0] cfg_wdata = '0;

  triangle_span_rasteriser u_dut (.*);

  always #5 clk = ~clk;

  // Predictor state mirrors the configuration registers
  logic [12:0] scr_w = 13'd640, scr_h = 13'd480;
  logic [11:0] tile_y = 12'd0;

  tri_t  pending_tris[$];
  span_t expected_spans[$];
  int    mismatches = 0;
  longint cycles = 0;
  bit    hold_off = 1'b0;
  bit    done = 1'b0;
  int unsigned sent_cnt = 0;
  int unsigned acc_cnt = 0;

  function automatic void queue_tri(tri_t t);
    pending_tris.insert(pending_tris.size(), t);
  endfunction

  function automatic longint inv_slope(longint dx, longint dy);
    longint q;
    if (dy == 0) return 0;
    q = (dx * 65536) / dy;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // ceil(x - 0.5) with x in 2^-(SUB+17) pixel units
  function automatic longint pixel_col(longint xs);
    longint half, a, q;
    half = longint'(1) << (SUB + 16);
    a = xs - half;
    q = a / (2 * half);
    if (a % (2 * half) != 0 && a > 0) q++;
    return q;
  endfunction

  // Walk the tile rows and queue the spans a triangle covers
  task automatic predict_spans(tri_t t);
    longint x[3], y[3], tmp, sl, su, sd, xmid, w, hl, rend, yc, xl, xs, c0, c1;
    bit short_left;
    int n;
    span_t s;
    x[0] = $signed(t.ax); y[0] = $signed(t.ay);
    x[1] = $signed(t.bx); y[1] = $signed(t.by);
    x[2] = $signed(t.cx); y[2] = $signed(t.cy);
    if (y[0] > y[1]) begin
      tmp = x[0]; x[0] = x[1]; x[1] = tmp; tmp = y[0]; y[0] = y[1]; y[1] = tmp;
    end
    if (y[0] > y[2]) begin
      tmp = x[0]; x[0] = x[2]; x[2] = tmp; tmp = y[0]; y[0] = y[2]; y[2] = tmp;
    end
    if (y[1] > y[2]) begin
      tmp = x[1]; x[1] = x[2]; x[2] = tmp; tmp = y[1]; y[1] = y[2]; y[2] = tmp;
    end
    sl = inv_slope(x[2] - x[0], y[2] - y[0]);
    su = inv_slope(x[1] - x[0], y[1] - y[0]);
    sd = inv_slope(x[2] - x[1], y[2] - y[1]);
    xmid = x[0] * 131072 + sl * (2 * (y[1] - y[0]));
    short_left = (x[1] * 131072) < xmid;
    w = (scr_w > 4096) ? 4096 : scr_w;
    hl = (scr_h > 4096) ? 4096 : scr_h;
    rend = tile_y + TILE_H;
    if (rend > hl) rend = hl;
    n = 0;
    for (longint r = tile_y; r < rend; r++) begin
      yc = (2 * r + 1) * (1 << SUB);
      if (yc < 2 * y[0] || yc >= 2 * y[2]) continue;
      xl = x[0] * 131072 + sl * (yc - 2 * y[0]);
      if (yc < 2 * y[1]) xs = x[0] * 131072 + su * (yc - 2 * y[0]);
      else xs = x[1] * 131072 + sd * (yc - 2 * y[1]);
      c0 = pixel_col(short_left ? xs : xl);
      c1 = pixel_col(short_left ? xl : xs);
      if (c0 < 0) c0 = 0;
      if (c1 > w) c1 = w;
      if (c0 >= c1) continue;
      s.row = r[11:0]; s.start_col = c0[12:0]; s.end_col = c1[12:0];
      s.colour = t.colour; s.last = 1'b0;
      expected_spans.insert(expected_spans.size(), s);
      n++;
    end
    if (n > 0) expected_spans[expected_spans.size() - 1].last = 1'b1;
  endtask

  // Driver: bursts with random gaps, fed from the pending queue
  int gap = 0;
  always @(negedge clk) begin
    if (sent_cnt != acc_cnt) begin
      // hold the transaction until it is taken
    end else if (!rst_n || hold_off) begin
      in_tvalid <= 1'b0;
    end else if (gap > 0) begin
      gap <= gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_tris.size() > 0) begin
      in_tdata <= pending_tris.pop_front();
      in_tvalid <= 1'b1;
      sent_cnt <= sent_cnt + 1;
      if ($urandom_range(0, 3) == 0) gap <= $urandom_range(1, 150);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver stall pattern: phases of always-ready and random stalls
  int stall_mode = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Monitor: predict on each input transaction, compare each span in order
  always @(posedge clk) begin
    span_t e;
    cycles <= cycles + 1;
    if (rst_n && in_tvalid && in_tready) begin
      predict_spans(in_tdata);
      acc_cnt <= acc_cnt + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected span %h last %b", out_tdata, out_tlast);
      end else begin
        e = expected_spans.pop_front();
        if (out_tdata[11:0] !== e.row || out_tdata[24:12] !== e.start_col ||
            out_tdata[37:25] !== e.end_col || out_tdata[61:38] !== e.colour ||
            out_tdata[63:62] !== 2'b00 || out_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("span mismatch: exp row %0d %0d..%0d col %h last %b, got %h last %b",
                     e.row, e.start_col, e.end_col, e.colour, e.last, out_tdata, out_tlast);
        end
      end
    end
    if (cycles > LIMIT && !done) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] near_coord(int lo, int hi);
    return 16'($urandom_range(0, hi - lo) + lo);
  endfunction

  function automatic tri_t rand_tri(int span_x, int y0);
    tri_t t;
    int bx, by;
    bx = $urandom_range(0, span_x);
    by = y0 * 16 - 64;
    t.ax = near_coord(-200 + bx, 200 + bx * 16);
    t.ay = near_coord(by, by + 1300);
    t.bx = near_coord(-200 + bx, 200 + bx * 16);
    t.by = near_coord(by, by + 1300);
    t.cx = near_coord(-200 + bx, 200 + bx * 16);
    t.cy = near_coord(by, by + 1300);
    t.colour = 24'($urandom());
    return t;
  endfunction

  // Wait until every triangle is taken and every span has come out
  task automatic drain();
    do @(posedge clk);
    while (pending_tris.size() != 0 || in_tvalid || expected_spans.size() != 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [tsr_pkg::CFG_AW-1:0] idx, logic [tsr_pkg::CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tsr_pkg::CFG_SCREEN_WIDTH:  scr_w = val;
      tsr_pkg::CFG_SCREEN_HEIGHT: scr_h = val;
      tsr_pkg::CFG_TILE_TOP:      tile_y = val[11:0];
      default: ;
    endcase
  endtask

  function automatic tri_t mk(int ax, int ay, int bx, int by, int cx, int cy, int col);
    tri_t t;
    t.ax = 16'(ax); t.ay = 16'(ay); t.bx = 16'(bx); t.by = 16'(by);
    t.cx = 16'(cx); t.cy = 16'(cy); t.colour = 24'(col);
    return t;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: flat tops and bottoms, ties, slivers, extremes, degenerate
    queue_tri(mk(0, 0, 160, 0, 0, 160, 24'hFFFFFF));
    queue_tri(mk(0, 160, 160, 160, 80, 0, 24'h000000));
    queue_tri(mk(80, 0, 0, 320, 160, 160, 24'h123456));
    queue_tri(mk(160, 0, 200, 320, 0, 160, 24'hABCDEF));
    queue_tri(mk(8, 8, 8, 8, 8, 8, 24'h555555));
    queue_tri(mk(0, 40, 500, 40, 900, 40, 24'hAAAAAA));
    queue_tri(mk(-32768, -32768, 32767, -32768, 0, 32767, 24'hFF00FF));
    queue_tri(mk(32767, 32767, -32768, 32767, 0, -32768, 24'h00FF00));
    queue_tri(mk(-32768, 0, 32767, 8, -32768, 1023, 24'h0F0F0F));
    queue_tri(mk(8, 8, 24, 8, 8, 24, 24'hF0F0F0));
    queue_tri(mk(7, 7, 9, 7, 7, 9, 24'h010203));
    queue_tri(mk(100, 0, 101, 1000, 100, 500, 24'h804020));
    queue_tri(mk(-500, 10, -100, 500, -300, 900, 24'h112233));
    queue_tri(mk(10000, 0, 12000, 900, 11000, 400, 24'h445566));
    queue_tri(mk(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0, 0, 24'h800001));
    drain();

    write_reg(tsr_pkg::CFG_SCREEN_WIDTH, 13'd1);
    write_reg(tsr_pkg::CFG_SCREEN_HEIGHT, 13'd8191);
    write_reg(tsr_pkg::CFG_TILE_TOP, 13'd4095);
    queue_tri(mk(-100, 65000 - 65536, 200, 32767, -100, 32767, 24'h0000FF));
    queue_tri(mk(0, 0, 200, 800, 0, 800, 24'hFF0000));
    drain();
    write_reg(tsr_pkg::CFG_SCREEN_WIDTH, 13'd8191);
    write_reg(tsr_pkg::CFG_SCREEN_HEIGHT, 13'd4096);
    write_reg(tsr_pkg::CFG_TILE_TOP, 13'd2040);
    queue_tri(mk(-32768, 32000, 32767, 32767, 32767, 32000, 24'h00FFFF));
    queue_tri(mk(-32768, 32767, 32767, 32760, 0, 32000, 24'h7F7F7F));
    drain();
    write_reg(tsr_pkg::CFG_SCREEN_WIDTH, 13'd0);
    write_reg(tsr_pkg::CFG_SCREEN_HEIGHT, 13'd0);
    queue_tri(mk(0, 32000, 800, 32767, 0, 32767, 24'h333333));
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 5; ph++) begin
      int ty;
      write_reg(tsr_pkg::CFG_SCREEN_WIDTH, 13'($urandom_range(1, 5000)));
      write_reg(tsr_pkg::CFG_SCREEN_HEIGHT, 13'($urandom_range(100, 8191)));
      ty = (ph == 0) ? 0 : $urandom_range(0, 1900);
      write_reg(tsr_pkg::CFG_TILE_TOP, 13'(ty));
      for (int i = 0; i < 24; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          tri_t t;
          t = 120'({$urandom(), $urandom(), $urandom(), $urandom()});
          queue_tri(t);
        end else begin
          queue_tri(rand_tri(1500, ty));
        end
        if (i == 12) begin
          // pause the sender until every expected span is out
          do @(posedge clk);
          while (pending_tris.size() != 0 || in_tvalid);
          hold_off = 1'b1;
          do @(posedge clk);
          while (expected_spans.size() != 0);
          hold_off = 1'b0;
        end
      end
      drain();
    end

    done = 1'b1;
    if (mismatches == 0 && expected_spans.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
